[hw/rtl/cdc_pkg.sv]
package cdc_pkg;

    // Calendar span and field widths.
    localparam int C_EPOCH_YEAR = 1970;
    localparam int C_YEAR_SPAN  = 256;

    localparam int C_CMD_W   = 2;
    localparam int C_DAY_W   = 5;
    localparam int C_MONTH_W = 4;
    localparam int C_YEAR_W  = 12;
    localparam int C_OFF_W   = 18;
    localparam int C_COUNT_W = 17;
    localparam int C_DIFF_W  = 18;
    localparam int C_ACC_W   = 19;
    localparam int C_YLEN_W  = 9;

    // Leap years in the span, counted with the divisibility rule.
    localparam int C_LAST_YEAR_I = C_EPOCH_YEAR + C_YEAR_SPAN - 1;
    localparam int C_LEAPS_HI    = C_LAST_YEAR_I / 4 - C_LAST_YEAR_I / 100
                                 + C_LAST_YEAR_I / 400;
    localparam int C_LEAPS_LO    = (C_EPOCH_YEAR - 1) / 4 - (C_EPOCH_YEAR - 1) / 100
                                 + (C_EPOCH_YEAR - 1) / 400;
    localparam int C_SPAN_DAYS_I = C_YEAR_SPAN * 365 + C_LEAPS_HI - C_LEAPS_LO;

    localparam logic [C_YEAR_W-1:0]  C_EPOCH     = C_YEAR_W'(C_EPOCH_YEAR);
    localparam logic [C_YEAR_W-1:0]  C_LAST_YEAR = C_YEAR_W'(C_LAST_YEAR_I);
    localparam logic [C_ACC_W-1:0]   C_SPAN_DAYS = C_ACC_W'(C_SPAN_DAYS_I);
    localparam logic [C_COUNT_W-1:0] C_LAST_COUNT = C_COUNT_W'(C_SPAN_DAYS_I - 1);

    // Residues of the epoch year for the leap-year counters.
    localparam logic [1:0] C_EPOCH_MOD4   = 2'(C_EPOCH_YEAR % 4);
    localparam logic [6:0] C_EPOCH_MOD100 = 7'(C_EPOCH_YEAR % 100);
    localparam logic [8:0] C_EPOCH_MOD400 = 9'(C_EPOCH_YEAR % 400);

    localparam logic [C_MONTH_W-1:0] C_JAN = 4'd1;
    localparam logic [C_MONTH_W-1:0] C_FEB = 4'd2;
    localparam logic [C_MONTH_W-1:0] C_DEC = 4'd12;

    // Command codes.
    localparam logic [C_CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [C_CMD_W-1:0] CMD_ADD  = 2'd1;
    localparam logic [C_CMD_W-1:0] CMD_DIFF = 2'd2;

    typedef logic signed [C_ACC_W-1:0] t_acc;

    // Controls from the sequencer to the calendar walker.
    typedef struct packed {
        logic clear;
        logic step_year;
        logic step_month;
    } t_walk_ctl;

    // Position and lengths reported by the calendar walker.
    typedef struct packed {
        logic [C_YEAR_W-1:0]  year;
        logic [C_MONTH_W-1:0] month;
        logic [C_YLEN_W-1:0]  year_len;
        logic [C_DAY_W-1:0]   month_len;
    } t_walk_st;

    // Days in a month; months outside one to twelve have no days.
    function automatic logic [C_DAY_W-1:0] month_days(input logic [C_MONTH_W-1:0] m,
                                                      input logic leap);
        logic [C_DAY_W-1:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

[hw/rtl/cdc_ifs.sv]
// Command channel: one word per calendar command.
interface cdc_in_if import cdc_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [C_CMD_W-1:0]           cmd;
    logic [C_DAY_W-1:0]           day_in;
    logic [C_MONTH_W-1:0]         month_in;
    logic [C_YEAR_W-1:0]          year_in;
    logic signed [C_OFF_W-1:0]    offset;

    modport source (output valid, cmd, day_in, month_in, year_in, offset, input ready);
    modport sink   (input valid, cmd, day_in, month_in, year_in, offset, output ready);
endinterface

// Result channel: one word per command.
interface cdc_out_if import cdc_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [C_DAY_W-1:0]           day_out;
    logic [C_MONTH_W-1:0]         month_out;
    logic [C_YEAR_W-1:0]          year_out;
    logic [C_COUNT_W-1:0]         day_count;
    logic signed [C_DIFF_W-1:0]   difference;
    logic                         out_of_range;

    modport source (output valid, day_out, month_out, year_out, day_count, difference,
                    out_of_range, input ready);
    modport sink   (input valid, day_out, month_out, year_out, day_count, difference,
                    out_of_range, output ready);
endinterface

[hw/rtl/cdc_alu.sv]
// Shared adder and subtractor used by the add, encode, clamp, apply and decode steps of the sequencer.
module cdc_alu import cdc_pkg::*; (
    input  t_acc i_a,
    input  t_acc i_b,
    input  logic i_sub,
    output t_acc o_res,
    output logic o_neg
);

    // Subtraction is done as addition of the inverted operand plus one.
    always_comb begin
        o_res = i_a + (i_sub ? ~i_b : i_b) + t_acc'(i_sub);
        o_neg = o_res[C_ACC_W-1];
    end

endmodule

[hw/rtl/cdc_walk.sv]
// Calendar walker: current year and month, with the lengths that go with them.
module cdc_walk import cdc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_walk_ctl i_ctl,
    output t_walk_st  o_st
);

    logic [C_YEAR_W-1:0]  r_year,   n_year;
    logic [C_MONTH_W-1:0] r_month,  n_month;
    logic [1:0]           r_mod4,   n_mod4;
    logic [6:0]           r_mod100, n_mod100;
    logic [8:0]           r_mod400, n_mod400;
    logic                 leap;

    // Leap rule from the running residues of the year.
    always_comb begin
        leap = ((r_mod4 == 2'd0) && (r_mod100 != 7'd0)) || (r_mod400 == 9'd0);
        o_st.year      = r_year;
        o_st.month     = r_month;
        o_st.year_len  = leap ? 9'd366 : 9'd365;
        o_st.month_len = month_days(r_month, leap);
    end

    // Next position: restart at the epoch, or step one year or one month.
    always_comb begin
        n_year   = r_year;
        n_month  = r_month;
        n_mod4   = r_mod4;
        n_mod100 = r_mod100;
        n_mod400 = r_mod400;
        if (i_ctl.clear) begin
            n_year   = C_EPOCH;
            n_month  = C_JAN;
            n_mod4   = C_EPOCH_MOD4;
            n_mod100 = C_EPOCH_MOD100;
            n_mod400 = C_EPOCH_MOD400;
        end else if (i_ctl.step_year) begin
            n_year   = r_year + 12'd1;
            n_mod4   = r_mod4 + 2'd1;
            n_mod100 = (r_mod100 == 7'd99) ? 7'd0 : r_mod100 + 7'd1;
            n_mod400 = (r_mod400 == 9'd399) ? 9'd0 : r_mod400 + 9'd1;
        end else if (i_ctl.step_month) begin
            n_month  = r_month + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year   <= C_EPOCH;
            r_month  <= C_JAN;
            r_mod4   <= C_EPOCH_MOD4;
            r_mod100 <= C_EPOCH_MOD100;
            r_mod400 <= C_EPOCH_MOD400;
        end else begin
            r_year   <= n_year;
            r_month  <= n_month;
            r_mod4   <= n_mod4;
            r_mod100 <= n_mod100;
            r_mod400 <= n_mod400;
        end
    end

endmodule

[hw/rtl/calendar_day_counter_top.sv]
// Calendar day counter. The block holds one date as a count of days since
// 1 January of the epoch year and takes one command word at a time on i_in:
// load a day, month and year, add a signed offset, or compare against a given
// date. Each command gives exactly one result word on o_out with the stored
// date decoded into day, month and year, the stored count, the difference
// (difference command only, else zero) and a flag for a count that was
// clamped to the span.
// A load or difference walks from the epoch to the given year one year per
// cycle, then month by month, then decodes the stored count the same way, all
// through one shared adder. An add clamps, applies and decodes; an unused
// command only decodes. The next word is taken once the result has gone to
// the output register.
// i_in.ready is high only while the sequencer is idle. A finished result sits
// in the output register; if o_out is stalled the block still takes the next
// command and holds its own result until the register is free.
// Reset sets the stored count to zero, the first day of the epoch year, and
// empties the output register.
module calendar_day_counter_top import cdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdc_in_if.sink      i_in,
    cdc_out_if.source   o_out
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ENC_Y = 4'd1;
    localparam logic [3:0] S_ENC_M = 4'd2;
    localparam logic [3:0] S_ENC_D = 4'd3;
    localparam logic [3:0] S_CLAMP = 4'd4;
    localparam logic [3:0] S_APPLY = 4'd5;
    localparam logic [3:0] S_DEC_Y = 4'd6;
    localparam logic [3:0] S_DEC_M = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]                 r_state,  n_state;
    logic [C_CMD_W-1:0]         r_cmd,    n_cmd;
    logic [C_DAY_W-1:0]         r_day,    n_day;
    logic [C_MONTH_W-1:0]       r_month,  n_month;
    logic [C_YEAR_W-1:0]        r_year,   n_year;
    logic [C_COUNT_W-1:0]       r_stored, n_stored;
    t_acc                       r_acc,    n_acc;
    logic signed [C_DIFF_W-1:0] r_diff,   n_diff;
    logic                       r_flag,   n_flag;

    logic                       r_o_valid, n_o_valid;
    logic [C_DAY_W-1:0]         r_o_day,   n_o_day;
    logic [C_MONTH_W-1:0]       r_o_month, n_o_month;
    logic [C_YEAR_W-1:0]        r_o_year,  n_o_year;
    logic [C_COUNT_W-1:0]       r_o_count, n_o_count;
    logic signed [C_DIFF_W-1:0] r_o_diff,  n_o_diff;
    logic                       r_o_flag,  n_o_flag;

    t_acc      alu_a, alu_b, alu_res;
    logic      alu_sub, alu_neg;
    t_walk_ctl walk_ctl;
    t_walk_st  walk_st;
    logic      accept;
    t_acc      stored_ext;

    assign accept     = i_in.valid && i_in.ready;
    assign stored_ext = t_acc'({2'b00, r_stored});

    cdc_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_res (alu_res),
        .o_neg (alu_neg)
    );

    cdc_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (walk_ctl),
        .o_st    (walk_st)
    );

    // Operands of the shared adder for each step.
    always_comb begin
        alu_a   = r_acc;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_IDLE: begin
                alu_a = stored_ext;
                alu_b = t_acc'(i_in.offset);
            end
            S_ENC_Y: alu_b = t_acc'({10'd0, walk_st.year_len});
            S_ENC_M: alu_b = t_acc'({14'd0, walk_st.month_len});
            S_ENC_D: alu_b = t_acc'({14'd0, r_day});
            S_CLAMP: begin
                alu_b   = C_SPAN_DAYS;
                alu_sub = 1'b1;
            end
            S_APPLY: begin
                alu_a   = stored_ext;
                alu_b   = r_acc;
                alu_sub = 1'b1;
            end
            S_DEC_Y: begin
                alu_b   = t_acc'({10'd0, walk_st.year_len});
                alu_sub = 1'b1;
            end
            S_DEC_M: begin
                alu_b   = t_acc'({14'd0, walk_st.month_len});
                alu_sub = 1'b1;
            end
            default: alu_b = '0;
        endcase
    end

    // Sequencer: encode the date or add the offset, clamp, apply, decode the count.
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_day    = r_day;
        n_month  = r_month;
        n_year   = r_year;
        n_stored = r_stored;
        n_acc    = r_acc;
        n_diff   = r_diff;
        n_flag   = r_flag;
        walk_ctl = '0;

        n_o_valid = r_o_valid && !o_out.ready;
        n_o_day   = r_o_day;
        n_o_month = r_o_month;
        n_o_year  = r_o_year;
        n_o_count = r_o_count;
        n_o_diff  = r_o_diff;
        n_o_flag  = r_o_flag;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd  = i_in.cmd;
                    n_day  = i_in.day_in;
                    n_year = i_in.year_in;
                    n_diff = '0;
                    n_flag = 1'b0;
                    walk_ctl.clear = 1'b1;
                    // Month zero counts as January, months past twelve as December.
                    if (i_in.month_in == 4'd0) begin
                        n_month = C_JAN;
                    end else if (i_in.month_in > C_DEC) begin
                        n_month = C_DEC;
                    end else begin
                        n_month = i_in.month_in;
                    end
                    case (i_in.cmd)
                        CMD_LOAD, CMD_DIFF: begin
                            if (i_in.year_in < C_EPOCH) begin
                                n_acc   = '0;
                                n_flag  = 1'b1;
                                n_state = S_APPLY;
                            end else if (i_in.year_in > C_LAST_YEAR) begin
                                n_acc   = t_acc'({2'b00, C_LAST_COUNT});
                                n_flag  = 1'b1;
                                n_state = S_APPLY;
                            end else begin
                                // Start at minus one so that adding the day lands on it.
                                n_acc   = -t_acc'(1);
                                n_state = S_ENC_Y;
                            end
                        end
                        CMD_ADD: begin
                            n_acc   = alu_res;
                            n_state = S_CLAMP;
                        end
                        default: begin
                            n_acc   = stored_ext;
                            n_state = S_DEC_Y;
                        end
                    endcase
                end
            end
            S_ENC_Y: begin
                if (walk_st.year != r_year) begin
                    n_acc              = alu_res;
                    walk_ctl.step_year = 1'b1;
                end else begin
                    n_state = S_ENC_M;
                end
            end
            S_ENC_M: begin
                if (walk_st.month != r_month) begin
                    n_acc               = alu_res;
                    walk_ctl.step_month = 1'b1;
                end else begin
                    n_state = S_ENC_D;
                end
            end
            S_ENC_D: begin
                n_acc   = alu_res;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                // Below zero goes to the first day, past the span to the last.
                if (r_acc[C_ACC_W-1]) begin
                    n_acc  = '0;
                    n_flag = 1'b1;
                end else if (!alu_neg) begin
                    n_acc  = t_acc'({2'b00, C_LAST_COUNT});
                    n_flag = 1'b1;
                end
                n_state = S_APPLY;
            end
            S_APPLY: begin
                walk_ctl.clear = 1'b1;
                if (r_cmd == CMD_DIFF) begin
                    n_diff = alu_res[C_DIFF_W-1:0];
                    n_acc  = stored_ext;
                end else begin
                    n_stored = r_acc[C_COUNT_W-1:0];
                end
                n_state = S_DEC_Y;
            end
            S_DEC_Y: begin
                if ((walk_st.year != C_LAST_YEAR) && !alu_neg) begin
                    n_acc              = alu_res;
                    walk_ctl.step_year = 1'b1;
                end else begin
                    n_state = S_DEC_M;
                end
            end
            S_DEC_M: begin
                if ((walk_st.month != C_DEC) && !alu_neg) begin
                    n_acc               = alu_res;
                    walk_ctl.step_month = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hand the word to the output register once it is free.
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid = 1'b1;
                    n_o_day   = r_acc[C_DAY_W-1:0] + 5'd1;
                    n_o_month = walk_st.month;
                    n_o_year  = walk_st.year;
                    n_o_count = r_stored;
                    n_o_diff  = r_diff;
                    n_o_flag  = r_flag;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and the stored count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_stored  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_stored  <= n_stored;
            r_o_valid <= n_o_valid;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_day     <= n_day;
        r_month   <= n_month;
        r_year    <= n_year;
        r_acc     <= n_acc;
        r_diff    <= n_diff;
        r_flag    <= n_flag;
        r_o_day   <= n_o_day;
        r_o_month <= n_o_month;
        r_o_year  <= n_o_year;
        r_o_count <= n_o_count;
        r_o_diff  <= n_o_diff;
        r_o_flag  <= n_o_flag;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_o_valid;
    assign o_out.day_out      = r_o_day;
    assign o_out.month_out    = r_o_month;
    assign o_out.year_out     = r_o_year;
    assign o_out.day_count    = r_o_count;
    assign o_out.difference   = r_o_diff;
    assign o_out.out_of_range = r_o_flag;

endmodule

[hw/rtl/cdc_chk.sv]
// Port-level checks for the calendar day counter.
module cdc_chk import cdc_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [C_DAY_W-1:0]   i_day_out,
    input logic [C_MONTH_W-1:0] i_month_out,
    input logic [C_YEAR_W-1:0]  i_year_out,
    input logic [C_COUNT_W-1:0] i_day_count
);

    // A result word stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // The sequencer is busy in the cycle after it takes a command.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command taken while the previous one is still in work");

    // A decoded date always has a month of one to twelve, a day of one to 31 and a year in the span.
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_month_out >= C_JAN) && (i_month_out <= C_DEC)
                        && (i_day_out >= 5'd1) && (i_day_out <= 5'd31)
                        && (i_year_out >= C_EPOCH) && (i_year_out <= C_LAST_YEAR))
        else $error("decoded date outside the calendar span");

    // The stored count never leaves the span.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_day_count <= C_LAST_COUNT)
        else $error("day count past the last day of the span");

endmodule

bind calendar_day_counter_top cdc_chk u_cdc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_day_out   (o_out.day_out),
    .i_month_out (o_out.month_out),
    .i_year_out  (o_out.year_out),
    .i_day_count (o_out.day_count)
);

[sim/calendar_day_counter_top_test.sv]
module calendar_day_counter_top_test import cdc_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    // The command field has one code that leaves the stored date unchanged.
    localparam logic [C_CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int LONG_HOLD     = 3000;
    localparam int SETTLE_CYCLES = 600;

    typedef struct {
        logic [C_CMD_W-1:0]        cmd;
        logic [C_DAY_W-1:0]        day;
        logic [C_MONTH_W-1:0]      month;
        logic [C_YEAR_W-1:0]       year;
        logic signed [C_OFF_W-1:0] offset;
    } cmd_word_t;

    typedef struct {
        logic [C_DAY_W-1:0]         day;
        logic [C_MONTH_W-1:0]       month;
        logic [C_YEAR_W-1:0]        year;
        logic [C_COUNT_W-1:0]       count;
        logic signed [C_DIFF_W-1:0] difference;
        logic                       out_of_range;
    } date_result_t;

    logic i_clk;
    logic i_rst_n;

    cdc_in_if  cmd_bus ();
    cdc_out_if result_bus ();

    calendar_day_counter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_bus),
        .o_out   (result_bus)
    );

    date_result_t pending_dates[$];
    int           held_days;
    int           span_top;
    int           error_count;
    int           cycle_count;
    int           hold_request;
    bit           steady_flow;

    // Calendar rules used to predict the stored date.
    function automatic bit is_leap(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_year(int y);
        return is_leap(y) ? 366 : 365;
    endfunction

    function automatic int days_in_month(int m, int y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic int clamp_to_span(int c, inout bit clipped);
        if (c < 0) begin
            clipped = 1'b1;
            return 0;
        end
        if (c > span_top) begin
            clipped = 1'b1;
            return span_top;
        end
        return c;
    endfunction

    // Count of days from the first day of the epoch year to a given date.
    function automatic int date_to_days(int d, int m, int y, inout bit clipped);
        int total;
        int i;
        int mm;
        if (y < C_EPOCH_YEAR) begin
            clipped = 1'b1;
            return 0;
        end
        if (y >= C_EPOCH_YEAR + C_YEAR_SPAN) begin
            clipped = 1'b1;
            return span_top;
        end
        mm = (m < 1) ? 1 : ((m > 12) ? 12 : m);
        total = 0;
        for (i = C_EPOCH_YEAR; i < y; i++) total += days_in_year(i);
        for (i = 1; i < mm; i++) total += days_in_month(i, y);
        total += d - 1;
        return clamp_to_span(total, clipped);
    endfunction

    // Decode a day count by walking whole years, then whole months.
    function automatic void days_to_date(int count, output int d, output int m,
                                         output int y);
        int rest;
        int k;
        rest = count;
        y = C_EPOCH_YEAR;
        m = 1;
        for (k = 0; k < C_YEAR_SPAN - 1 && rest >= days_in_year(y); k++) begin
            rest -= days_in_year(y);
            y++;
        end
        while (m < 12 && rest >= days_in_month(m, y)) begin
            rest -= days_in_month(m, y);
            m++;
        end
        d = rest + 1;
    endfunction

    // Apply one command to the predicted stored count and build its result.
    function automatic date_result_t step_calendar(cmd_word_t w);
        date_result_t r;
        bit           clipped;
        int           given;
        int           d;
        int           m;
        int           y;
        clipped = 1'b0;
        r.difference = '0;
        case (w.cmd)
            CMD_LOAD: held_days = date_to_days(w.day, w.month, w.year, clipped);
            CMD_ADD:  held_days = clamp_to_span(held_days + int'(w.offset), clipped);
            CMD_DIFF: begin
                given = date_to_days(w.day, w.month, w.year, clipped);
                r.difference = C_DIFF_W'(held_days - given);
            end
            default: ;
        endcase
        days_to_date(held_days, d, m, y);
        r.day          = C_DAY_W'(d);
        r.month        = C_MONTH_W'(m);
        r.year         = C_YEAR_W'(y);
        r.count        = C_COUNT_W'(held_days);
        r.out_of_range = clipped;
        return r;
    endfunction

    function automatic cmd_word_t cmd_word(logic [C_CMD_W-1:0] c, int d, int m, int y,
                                           int off);
        cmd_word_t w;
        w.cmd    = c;
        w.day    = C_DAY_W'(d);
        w.month  = C_MONTH_W'(m);
        w.year   = C_YEAR_W'(y);
        w.offset = C_OFF_W'(off);
        return w;
    endfunction

    // Mostly valid dates in the span with a mix of commands; now and then raw noise.
    function automatic cmd_word_t random_word();
        cmd_word_t w;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            w.cmd = CMD_LOAD;
        end else if (pick < 70) begin
            w.cmd = CMD_ADD;
        end else if (pick < 97) begin
            w.cmd = CMD_DIFF;
        end else begin
            w.cmd = CMD_UNUSED;
        end
        if ($urandom_range(0, 19) == 0) begin
            w.day   = C_DAY_W'($urandom);
            w.month = C_MONTH_W'($urandom);
            w.year  = C_YEAR_W'($urandom);
        end else begin
            w.day   = C_DAY_W'($urandom_range(1, 31));
            w.month = C_MONTH_W'($urandom_range(1, 12));
            w.year  = C_YEAR_W'($urandom_range(C_EPOCH_YEAR, C_EPOCH_YEAR + C_YEAR_SPAN - 1));
        end
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            w.offset = C_OFF_W'(int'($urandom_range(0, 800)) - 400);
        end else if (pick < 8) begin
            w.offset = C_OFF_W'(int'($urandom_range(0, 80000)) - 40000);
        end else begin
            w.offset = C_OFF_W'($urandom);
        end
        return w;
    endfunction

    // Idle length: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // Offer one command word and record its expected result once accepted.
    task automatic send_cmd(input cmd_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.cmd      <= w.cmd;
        cmd_bus.day_in   <= w.day;
        cmd_bus.month_in <= w.month;
        cmd_bus.year_in  <= w.year;
        cmd_bus.offset   <= w.offset;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        pending_dates.push_back(step_calendar(w));
    endtask

    task automatic wait_for_results();
        cmd_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_dates.size() != 0);
    endtask

    task automatic check_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Loads at the span edges, leap rules and each out-of-range date form.
    task automatic test_load_dates();
        send_cmd(cmd_word(CMD_LOAD, 1, 1, 1970, 0));
        send_cmd(cmd_word(CMD_LOAD, 31, 12, 2225, 0));
        send_cmd(cmd_word(CMD_LOAD, 29, 2, 2000, 0));
        send_cmd(cmd_word(CMD_LOAD, 29, 2, 2100, 0));
        send_cmd(cmd_word(CMD_LOAD, 31, 2, 2024, 0));
        send_cmd(cmd_word(CMD_LOAD, 0, 3, 2001, 0));
        send_cmd(cmd_word(CMD_LOAD, 0, 1, 1970, 0));
        send_cmd(cmd_word(CMD_LOAD, 15, 0, 1999, 0));
        send_cmd(cmd_word(CMD_LOAD, 15, 15, 1999, 0));
        send_cmd(cmd_word(CMD_LOAD, 20, 6, 1969, 0));
        send_cmd(cmd_word(CMD_LOAD, 31, 15, 4095, 0));
        send_cmd(cmd_word(CMD_LOAD, 0, 0, 0, 0));
        send_cmd(cmd_word(CMD_UNUSED, 31, 15, 4095, -131072));
    endtask

    // Offsets across a year end and up to both clamps.
    task automatic test_add_offsets();
        send_cmd(cmd_word(CMD_LOAD, 31, 12, 1999, 0));
        send_cmd(cmd_word(CMD_ADD, 0, 0, 0, 1));
        send_cmd(cmd_word(CMD_ADD, 0, 0, 0, 131071));
        send_cmd(cmd_word(CMD_ADD, 0, 0, 0, 0));
        send_cmd(cmd_word(CMD_ADD, 0, 0, 0, -131072));
        send_cmd(cmd_word(CMD_ADD, 0, 0, 0, -1));
        send_cmd(cmd_word(CMD_ADD, 0, 0, 0, 93501));
    endtask

    // Differences of both signs, zero, and against clamped dates.
    task automatic test_differences();
        send_cmd(cmd_word(CMD_DIFF, 31, 12, 2225, 0));
        send_cmd(cmd_word(CMD_LOAD, 15, 6, 2100, 0));
        send_cmd(cmd_word(CMD_DIFF, 15, 6, 2100, 0));
        send_cmd(cmd_word(CMD_DIFF, 31, 15, 2225, 0));
        send_cmd(cmd_word(CMD_DIFF, 1, 1, 1970, 0));
        send_cmd(cmd_word(CMD_DIFF, 1, 1, 3000, 0));
        send_cmd(cmd_word(CMD_DIFF, 0, 1, 1970, 0));
    endtask

    // Random command words, with one stretch where neither side idles.
    task automatic test_random_commands(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            steady_flow = (i >= 200 && i < 300);
            send_cmd(random_word());
        end
        steady_flow = 1'b0;
    endtask

    // The receiver holds off while words keep coming, so the block must stall its input.
    task automatic test_result_backpressure();
        int i;
        hold_request = LONG_HOLD;
        for (i = 0; i < 6; i++) send_cmd(random_word());
        wait_for_results();
    endtask

    // The sender waits for every pending result, then sends four more words.
    task automatic test_sender_pause();
        int i;
        wait_for_results();
        for (i = 0; i < 4; i++) send_cmd(random_word());
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("calendar_day_counter_top regression: fail");
        $finish;
    end

    // Receiver: random stalls, plus a long hold when a test asks for one.
    initial begin : result_sink
        int idle_left;
        idle_left = 0;
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                idle_left = hold_request;
                hold_request = 0;
            end
            if (idle_left > 0) begin
                result_bus.ready <= 1'b0;
                idle_left--;
            end else begin
                result_bus.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) idle_left = pick_gap();
            end
        end
    end

    // Compare each accepted result word with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        date_result_t want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (pending_dates.size() == 0) begin
                $display("%0t: result word with no prediction pending: count %0d",
                         $time, result_bus.day_count);
                error_count++;
            end else begin
                want = pending_dates.pop_front();
                check_field("day_out", want.day, result_bus.day_out);
                check_field("month_out", want.month, result_bus.month_out);
                check_field("year_out", want.year, result_bus.year_out);
                check_field("day_count", want.count, result_bus.day_count);
                check_field("difference", want.difference, result_bus.difference);
                check_field("out_of_range", want.out_of_range, result_bus.out_of_range);
            end
        end
    end

    initial begin : run
        int y;
        error_count  = 0;
        hold_request = 0;
        steady_flow  = 1'b0;
        held_days    = 0;
        span_top     = -1;
        for (y = C_EPOCH_YEAR; y < C_EPOCH_YEAR + C_YEAR_SPAN; y++) span_top += days_in_year(y);

        i_rst_n          <= 1'b0;
        cmd_bus.valid    <= 1'b0;
        cmd_bus.cmd      <= CMD_LOAD;
        cmd_bus.day_in   <= '0;
        cmd_bus.month_in <= '0;
        cmd_bus.year_in  <= '0;
        cmd_bus.offset   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_load_dates();
        test_add_offsets();
        test_differences();
        test_random_commands(750);
        test_result_backpressure();
        test_sender_pause();
        test_random_commands(750);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_dates.size() == 0) begin
            $display("calendar_day_counter_top regression: pass");
        end else begin
            $display("calendar_day_counter_top regression: fail");
        end
        $finish;
    end

endmodule
